FILE: hdl/akvt_pkg.sv
// Shared types, defaults and result codes for the associative key/value table.
package akvt_pkg;

	// Default geometry
	localparam int ENTRIES_DEF     = 16;
	localparam int KEY_BYTES_DEF   = 8;
	localparam int VALUE_BYTES_DEF = 8;

	// Port field widths
	localparam int FIELD_W  = 64;
	localparam int STATUS_W = 3;
	localparam int EIDX_W   = 4;

	// Request kinds
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Result codes
	localparam logic [STATUS_W-1:0] ST_OVERWRITTEN = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EMPTY_KEY   = 3'd5;

	// Control part of the search token that walks the cell row
	typedef struct packed {
		logic vld;
		logic lookup;
		logic empty;
		logic hit;
		logic free;
	} akvt_ctl_t;

endpackage

FILE: hdl/associative_key_value_table.sv
// Top level of the associative key/value table: request intake, cell row, result register.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: key, value
//  m_*       out  m_tvalid/m_tready  tuser: status; tdata: value_out, entry_index
//
// An accepted request becomes a search token that walks the row of entry cells,
// one cell per cycle, gathering the first matching entry and the first free one.
// When it leaves the last cell the insert (if any) is written back to its entry.
// An accepted request passes the injection register, the cell row, the pending
// result and the output register. A new request is taken once the previous
// one has reached the result register, even while that result still waits.
// Reset clears every stored key (all entries free) and all control state.
module associative_key_value_table #(
	parameter int ENTRIES     = akvt_pkg::ENTRIES_DEF,
	parameter int KEY_BYTES   = akvt_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BYTES = akvt_pkg::VALUE_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // [63:0] key, [127:64] value
	input  logic         s_tuser,  // [0] req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,  // [63:0] value_out, [67:64] entry_index, [71:68] zero
	output logic [2:0]   m_tuser   // [2:0] status
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KEY_W = KEY_BYTES * 8;
	localparam int VAL_W = VALUE_BYTES * 8;
	localparam int FW    = akvt_pkg::FIELD_W;
	localparam int SW    = akvt_pkg::STATUS_W;
	localparam int EW    = akvt_pkg::EIDX_W;

	// Sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;

	// Token links: index 0 is the injection register, index i+1 leaves cell i
	akvt_pkg::akvt_ctl_t ctl_c      [0:ENTRIES];
	logic [KEY_W-1:0]    key_c      [0:ENTRIES];
	logic [VAL_W-1:0]    val_c      [0:ENTRIES];
	logic [IDX_W-1:0]    hit_idx_c  [0:ENTRIES];
	logic [VAL_W-1:0]    hit_val_c  [0:ENTRIES];
	logic [IDX_W-1:0]    free_idx_c [0:ENTRIES];

	akvt_pkg::akvt_ctl_t inj_ctl_q;
	logic [KEY_W-1:0]    inj_key_q;
	logic [VAL_W-1:0]    inj_val_q;

	logic             in_acc;
	logic [KEY_W-1:0] in_key;
	logic [VAL_W-1:0] in_val;

	// Write-back and result decode at the end of the row
	akvt_pkg::akvt_ctl_t end_ctl;
	logic                end_vld;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic [SW-1:0]       res_status;
	logic [VAL_W-1:0]    res_val;
	logic [IDX_W-1:0]    res_idx;
	logic [IDX_W+EW-1:0] res_idx_ext;

	logic [SW-1:0]       pend_status_q;
	logic [VAL_W-1:0]    pend_val_q;
	logic [EW-1:0]       pend_idx_q;

	logic                m_valid_q;
	logic [SW-1:0]       out_status_q;
	logic [FW-1:0]       out_val_q;
	logic [EW-1:0]       out_idx_q;
	logic                out_load;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	// Drop key and value bits above the configured byte counts
	assign in_key   = s_tdata[KEY_W-1:0];
	assign in_val   = s_tdata[FW +: VAL_W];

	// Inject the token for one cycle on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_ctl_q <= '0;
		end else begin
			inj_ctl_q.vld    <= in_acc;
			inj_ctl_q.lookup <= (s_tuser == akvt_pkg::REQ_LOOKUP);
			inj_ctl_q.empty  <= (in_key == '0);
			inj_ctl_q.hit    <= 1'b0;
			inj_ctl_q.free   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			inj_key_q <= in_key;
			inj_val_q <= in_val;
		end
	end

	assign ctl_c[0]      = inj_ctl_q;
	assign key_c[0]      = inj_key_q;
	assign val_c[0]      = inj_val_q;
	assign hit_idx_c[0]  = '0;
	assign hit_val_c[0]  = '0;
	assign free_idx_c[0] = '0;

	// Row of entry cells
	for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
		akvt_cell #(
			.IDX   (gi),
			.IDX_W (IDX_W),
			.KEY_W (KEY_W),
			.VAL_W (VAL_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl_in       (ctl_c[gi]),
			.key_in       (key_c[gi]),
			.val_in       (val_c[gi]),
			.hit_idx_in   (hit_idx_c[gi]),
			.hit_val_in   (hit_val_c[gi]),
			.free_idx_in  (free_idx_c[gi]),
			.ctl_out      (ctl_c[gi+1]),
			.key_out      (key_c[gi+1]),
			.val_out      (val_c[gi+1]),
			.hit_idx_out  (hit_idx_c[gi+1]),
			.hit_val_out  (hit_val_c[gi+1]),
			.free_idx_out (free_idx_c[gi+1]),
			.wr_en        (wr_en),
			.wr_idx       (wr_idx),
			.wr_key       (key_c[ENTRIES]),
			.wr_val       (val_c[ENTRIES])
		);
	end

	assign end_ctl = ctl_c[ENTRIES];
	assign end_vld = (state_q == S_WALK) && end_ctl.vld;

	// Decode the finished search: empty key first, then lookup, then insert
	always_comb begin
		res_status = akvt_pkg::ST_EMPTY_KEY;
		res_val    = '0;
		res_idx    = '0;
		wr_idx     = hit_idx_c[ENTRIES];
		wr_en      = 1'b0;
		if (end_ctl.empty) begin
			res_status = akvt_pkg::ST_EMPTY_KEY;
		end else if (end_ctl.lookup) begin
			if (end_ctl.hit) begin
				res_status = akvt_pkg::ST_FOUND;
				res_val    = hit_val_c[ENTRIES];
				res_idx    = hit_idx_c[ENTRIES];
			end else begin
				res_status = akvt_pkg::ST_NOT_FOUND;
			end
		end else if (end_ctl.hit) begin
			res_status = akvt_pkg::ST_OVERWRITTEN;
			res_idx    = hit_idx_c[ENTRIES];
			wr_en      = end_vld;
		end else if (end_ctl.free) begin
			res_status = akvt_pkg::ST_INSERTED;
			res_idx    = free_idx_c[ENTRIES];
			wr_idx     = free_idx_c[ENTRIES];
			wr_en      = end_vld;
		end else begin
			res_status = akvt_pkg::ST_FULL;
		end
	end

	assign res_idx_ext = {{EW{1'b0}}, res_idx};

	// Hold the result until the output register is free
	always_ff @(posedge clk) begin
		if (end_vld) begin
			pend_status_q <= res_status;
			pend_val_q    <= res_val;
			pend_idx_q    <= res_idx_ext[EW-1:0];
		end
	end

	assign out_load = (state_q == S_DONE) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_WALK;
				end
				S_WALK: begin
					if (end_vld) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= pend_status_q;
			out_val_q    <= FW'(pend_val_q);
			out_idx_q    <= pend_idx_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'b0000, out_idx_q, out_val_q};

endmodule

FILE: hdl/akvt_cell.sv
// One table entry: stored key and value, plus one stage of the search token row.
module akvt_cell #(
	parameter int IDX   = 0,
	parameter int IDX_W = 4,
	parameter int KEY_W = 64,
	parameter int VAL_W = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  akvt_pkg::akvt_ctl_t ctl_in,
	input  logic [KEY_W-1:0]    key_in,
	input  logic [VAL_W-1:0]    val_in,
	input  logic [IDX_W-1:0]    hit_idx_in,
	input  logic [VAL_W-1:0]    hit_val_in,
	input  logic [IDX_W-1:0]    free_idx_in,
	output akvt_pkg::akvt_ctl_t ctl_out,
	output logic [KEY_W-1:0]    key_out,
	output logic [VAL_W-1:0]    val_out,
	output logic [IDX_W-1:0]    hit_idx_out,
	output logic [VAL_W-1:0]    hit_val_out,
	output logic [IDX_W-1:0]    free_idx_out,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_idx,
	input  logic [KEY_W-1:0]    wr_key,
	input  logic [VAL_W-1:0]    wr_val
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [KEY_W-1:0]    ent_key_q;
	logic [VAL_W-1:0]    ent_val_q;
	akvt_pkg::akvt_ctl_t ctl_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [VAL_W-1:0]    hit_val_q;
	logic [IDX_W-1:0]    free_idx_q;

	logic match;
	logic is_free;
	logic wr_here;
	logic first_hit;
	logic first_free;

	akvt_pkg::akvt_ctl_t ctl_d;
	logic [IDX_W-1:0]    hit_idx_d;
	logic [VAL_W-1:0]    hit_val_d;
	logic [IDX_W-1:0]    free_idx_d;

	assign match   = (ent_key_q == key_in);
	assign is_free = (ent_key_q == '0);
	assign wr_here = wr_en && (wr_idx == MY_IDX);

	// Key store: zero marks a free entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_key_q <= '0;
		end else if (wr_here) begin
			ent_key_q <= wr_key;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_here) begin
			ent_val_q <= wr_val;
		end
	end

	// Keep the first match and first free entry seen
	assign first_hit  = !ctl_in.hit && match;
	assign first_free = !ctl_in.free && is_free;

	always_comb begin
		ctl_d      = ctl_in;
		ctl_d.hit  = ctl_in.hit || match;
		ctl_d.free = ctl_in.free || is_free;
	end

	assign hit_idx_d  = first_hit ? MY_IDX : hit_idx_in;
	assign hit_val_d  = first_hit ? ent_val_q : hit_val_in;
	assign free_idx_d = first_free ? MY_IDX : free_idx_in;

	// Token control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_d;
		end
	end

	// Token payload
	always_ff @(posedge clk) begin
		key_q      <= key_in;
		val_q      <= val_in;
		hit_idx_q  <= hit_idx_d;
		hit_val_q  <= hit_val_d;
		free_idx_q <= free_idx_d;
	end

	assign ctl_out      = ctl_q;
	assign key_out      = key_q;
	assign val_out      = val_q;
	assign hit_idx_out  = hit_idx_q;
	assign hit_val_out  = hit_val_q;
	assign free_idx_out = free_idx_q;

endmodule
